// File: rtl/core/imk_pkg.sv
// ----------------------------------------------------------------------------
// imk_pkg
// Shared types and constants for the iambic Morse keyer: keyer states,
// keying modes, element codes, register map and the result item layout.
// ----------------------------------------------------------------------------
package imk_pkg;

    localparam int TIME_BITS_DEF = 32;

    // Register map (index = paddr[4:2]).
    localparam logic [2:0] REG_KEYER_MODE   = 3'd0;
    localparam logic [2:0] REG_PADDLE_SWAP  = 3'd1;
    localparam logic [2:0] REG_SPACING_MODE = 3'd2;
    localparam logic [2:0] REG_MEMORY_MASK  = 3'd3;
    localparam logic [2:0] REG_DOT_TICKS    = 3'd4;
    localparam logic [2:0] REG_WEIGHT       = 3'd5;
    localparam logic [2:0] REG_LAG_MS       = 3'd6;
    localparam logic [2:0] REG_SIDETONE     = 3'd7;

    // Register reset values.
    localparam logic [1:0]  RST_KEYER_MODE   = 2'd0;
    localparam logic [1:0]  RST_SPACING_MODE = 2'd1;
    localparam logic [1:0]  RST_MEMORY_MASK  = 2'd3;
    localparam logic [23:0] RST_DOT_TICKS    = 24'd66667;
    localparam logic [6:0]  RST_WEIGHT       = 7'd50;

    // Keying modes.
    localparam logic [1:0] MODE_IAMBIC    = 2'd0;
    localparam logic [1:0] MODE_ULTIMATIC = 2'd1;
    localparam logic [1:0] MODE_BUG       = 2'd2;
    localparam logic [1:0] MODE_STRAIGHT  = 2'd3;

    // Spacing enforcement levels.
    localparam logic [1:0] SPACE_NONE    = 2'd0;
    localparam logic [1:0] SPACE_ELEMENT = 2'd1;
    localparam logic [1:0] SPACE_CHAR    = 2'd2;
    localparam logic [1:0] SPACE_WORD    = 2'd3;

    // Element codes; the code also gives the length in dots.
    localparam logic [1:0] EL_NONE = 2'd0;
    localparam logic [1:0] EL_DIT  = 2'd1;
    localparam logic [1:0] EL_DAH  = 2'd3;

    // Keyer states.
    localparam logic [2:0] KS_MARK     = 3'd1;  // element sent, waiting to read paddles
    localparam logic [2:0] KS_GAP      = 3'd2;  // enforced spacing
    localparam logic [2:0] KS_IDLE     = 3'd3;  // idle, counting gaps
    localparam logic [2:0] KS_MAN_WAIT = 3'd4;  // manual key-down, waiting on spacing
    localparam logic [2:0] KS_MAN_DOWN = 3'd5;  // manual key held
    localparam logic [2:0] KS_MAN_UP   = 3'd6;  // manual key released

    localparam logic [2:0] GAP_RESET = 3'd2;
    localparam logic [2:0] GAP_CHAR  = 3'd1;
    localparam logic [2:0] GAP_WORD  = 3'd4;
    localparam logic [2:0] GAP_MAX   = 3'd7;

    localparam logic [7:0] CODE_EMPTY    = 8'h80;
    localparam logic [7:0] CODE_OVERFLOW = 8'hFF;
    localparam logic [7:0] CODE_LAST     = 8'h01;

    localparam int          TICKS_PER_MS = 1000;
    // Reciprocal for an exact unsigned 32-bit divide by 100: (x * M) >> 37.
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
    localparam int          DIV100_SHIFT = 37;

    typedef struct packed {
        logic       key_active;
        logic       sidetone_on;
        logic       element_started;
        logic       char_valid;
        logic [7:0] char_code;
        logic       tx_released;
    } result_t;

endpackage

// File: rtl/core/iambic_morse_keyer.sv
// ----------------------------------------------------------------------------
// iambic_morse_keyer
// Morse keyer with iambic, ultimatic, bug and straight modes, paddle swap,
// element memory, spacing enforcement, weighting, lag and release timing.
// ----------------------------------------------------------------------------
// The block takes one item per clock while s_ready is high: a timestamp and
// the two paddle contacts, and returns one result item per input item. The
// keyer state is updated in the cycle the item is accepted and the result
// lands in an output register backed by one skid entry, so one item per
// cycle is sustained while the result side keeps up. After reset and after
// every register write the element lengths are recomputed by a three-stage
// multiply and divide-by-100 pipeline, and s_ready stays low until the
// pipeline has refilled. All deadline compares use the sign of the wrapping difference over
// TIME_BITS bits.
module iambic_morse_keyer
    import imk_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [TIME_BITS-1:0] s_time_now,
    input  logic                 s_contact_a_n,
    input  logic                 s_contact_b_n,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_key_active,
    output logic                 m_sidetone_on,
    output logic                 m_element_started,
    output logic                 m_char_valid,
    output logic [7:0]           m_char_code,
    output logic                 m_tx_released,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int DW = 34;  // width of the signed element length arithmetic

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]  keyer_mode_reg;
    logic        paddle_swap_reg;
    logic [1:0]  spacing_mode_reg;
    logic [1:0]  memory_mask_reg;
    logic [23:0] dot_ticks_reg;
    logic [6:0]  weight_reg;
    logic [7:0]  lag_ms_reg;
    logic        sidetone_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keyer_mode_reg   <= RST_KEYER_MODE;
            paddle_swap_reg  <= 1'b0;
            spacing_mode_reg <= RST_SPACING_MODE;
            memory_mask_reg  <= RST_MEMORY_MASK;
            dot_ticks_reg    <= RST_DOT_TICKS;
            weight_reg       <= RST_WEIGHT;
            lag_ms_reg       <= 8'd0;
            sidetone_reg     <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_KEYER_MODE:   keyer_mode_reg   <= pwdata[1:0];
                REG_PADDLE_SWAP:  paddle_swap_reg  <= pwdata[0];
                REG_SPACING_MODE: spacing_mode_reg <= pwdata[1:0];
                REG_MEMORY_MASK:  memory_mask_reg  <= pwdata[1:0];
                REG_DOT_TICKS:    dot_ticks_reg    <= pwdata[23:0];
                REG_WEIGHT:       weight_reg       <= pwdata[6:0];
                REG_LAG_MS:       lag_ms_reg       <= pwdata[7:0];
                REG_SIDETONE:     sidetone_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_KEYER_MODE:   prdata = {30'd0, keyer_mode_reg};
            REG_PADDLE_SWAP:  prdata = {31'd0, paddle_swap_reg};
            REG_SPACING_MODE: prdata = {30'd0, spacing_mode_reg};
            REG_MEMORY_MASK:  prdata = {30'd0, memory_mask_reg};
            REG_DOT_TICKS:    prdata = {8'd0, dot_ticks_reg};
            REG_WEIGHT:       prdata = {25'd0, weight_reg};
            REG_LAG_MS:       prdata = {24'd0, lag_ms_reg};
            REG_SIDETONE:     prdata = {31'd0, sidetone_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Element length pipeline, recomputed after every register write.
    // Stage A forms dot*(2w-100) and dot*(200-2w), stage B divides the
    // magnitudes by 100, stage C builds the dit and dah offsets.
    // ------------------------------------------------------------------
    logic signed [8:0]    coef_mark;
    logic signed [8:0]    coef_space;
    logic signed [DW-1:0] dot_s;
    logic signed [DW-1:0] prod_mark_reg,  prod_mark_next;
    logic signed [DW-1:0] prod_space_reg, prod_space_next;
    logic [31:0]          mag_mark;
    logic [31:0]          mag_space;
    logic [63:0]          recip_mark;
    logic [63:0]          recip_space;
    logic [26:0]          quot_mark_reg,  quot_space_reg;
    logic                 neg_mark_reg,   neg_space_reg;
    logic signed [DW-1:0] adj_mark;
    logic signed [DW-1:0] adj_space;
    logic signed [DW-1:0] lag_ticks;
    logic signed [DW-1:0] len_dit;
    logic signed [DW-1:0] len_dah;
    logic [TIME_BITS-1:0] dit_key_reg,   dit_space_reg;
    logic [TIME_BITS-1:0] dah_key_reg,   dah_space_reg;
    logic [1:0]           busy_reg;

    assign coef_mark  = $signed({1'b0, weight_reg, 1'b0}) - 9'sd100;
    assign coef_space = 9'sd200 - $signed({1'b0, weight_reg, 1'b0});
    assign dot_s      = $signed({10'd0, dot_ticks_reg});

    assign prod_mark_next  = dot_s * DW'(coef_mark);
    assign prod_space_next = dot_s * DW'(coef_space);

    assign mag_mark    = prod_mark_reg[DW-1]  ? 32'(-prod_mark_reg)  : prod_mark_reg[31:0];
    assign mag_space   = prod_space_reg[DW-1] ? 32'(-prod_space_reg) : prod_space_reg[31:0];
    assign recip_mark  = 64'(mag_mark) * 64'(DIV100_MAGIC);
    assign recip_space = 64'(mag_space) * 64'(DIV100_MAGIC);

    assign adj_mark  = neg_mark_reg  ? -$signed({7'd0, quot_mark_reg})
                                     :  $signed({7'd0, quot_mark_reg});
    assign adj_space = neg_space_reg ? -$signed({7'd0, quot_space_reg})
                                     :  $signed({7'd0, quot_space_reg});
    assign lag_ticks = $signed(DW'(lag_ms_reg) * DW'(TICKS_PER_MS));
    assign len_dit   = dot_s + adj_mark;
    assign len_dah   = dot_s + (dot_s <<< 1) + adj_mark;

    always_ff @(posedge aclk) begin
        prod_mark_reg  <= prod_mark_next;
        prod_space_reg <= prod_space_next;
        quot_mark_reg  <= recip_mark[63:DIV100_SHIFT];
        quot_space_reg <= recip_space[63:DIV100_SHIFT];
        neg_mark_reg   <= prod_mark_reg[DW-1];
        neg_space_reg  <= prod_space_reg[DW-1];
        dit_key_reg    <= TIME_BITS'(len_dit + lag_ticks);
        dit_space_reg  <= TIME_BITS'(len_dit + adj_space);
        dah_key_reg    <= TIME_BITS'(len_dah + lag_ticks);
        dah_space_reg  <= TIME_BITS'(len_dah + adj_space);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            busy_reg <= 2'd3;
        end else if (busy_reg != 2'd0) begin
            busy_reg <= busy_reg - 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Keyer state
    // ------------------------------------------------------------------
    logic [2:0]           state_reg,     state_next;
    logic [1:0]           last_el_reg,   last_el_next;
    logic [2:0]           gap_reg,       gap_next;
    logic                 squeeze_reg,   squeeze_next;
    logic [1:0]           staged_reg,    staged_next;
    logic [7:0]           code_reg,      code_next;
    logic [TIME_BITS-1:0] read_dl_reg,   read_dl_next;
    logic [TIME_BITS-1:0] start_dl_reg,  start_dl_next;
    logic [TIME_BITS-1:0] rel_dl_reg,    rel_dl_next;
    logic                 key_on_reg,    key_on_next;
    logic                 released_reg,  released_next;

    logic                 s_accept;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] dot_t;
    logic                 dit;
    logic                 dah;
    logic                 do_idle;
    logic                 started;
    logic                 cvalid;
    logic [7:0]           ccode;
    result_t              result;

    function automatic logic past(input logic [TIME_BITS-1:0] deadline,
                                  input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] diff;
        diff = deadline - t;
        return diff[TIME_BITS-1];
    endfunction

    assign now   = s_time_now;
    assign dot_t = TIME_BITS'(dot_ticks_reg);

    always_comb begin
        state_next    = state_reg;
        last_el_next  = last_el_reg;
        gap_next      = gap_reg;
        squeeze_next  = squeeze_reg;
        staged_next   = staged_reg;
        code_next     = code_reg;
        read_dl_next  = read_dl_reg;
        start_dl_next = start_dl_reg;
        rel_dl_next   = rel_dl_reg;
        key_on_next   = key_on_reg;
        released_next = released_reg;
        do_idle       = 1'b0;
        started       = 1'b0;
        cvalid        = 1'b0;
        ccode         = 8'd0;

        if (keyer_mode_reg == MODE_STRAIGHT) begin
            dit = 1'b0;
            dah = !s_contact_a_n;
        end else if (!paddle_swap_reg) begin
            dit = !s_contact_a_n;
            dah = !s_contact_b_n;
        end else begin
            dit = !s_contact_b_n;
            dah = !s_contact_a_n;
        end

        case (state_reg)
            KS_MARK: begin
                // Without spacing enforcement, holding the same paddle repeats at once.
                if (spacing_mode_reg == SPACE_NONE &&
                    ((dit && last_el_reg == EL_DIT) || (dah && last_el_reg == EL_DAH))) begin
                    read_dl_next = now;
                end
                if (past(read_dl_next, now)) begin
                    state_next = KS_GAP;
                end
            end
            KS_GAP: begin
                if (past(start_dl_reg, now)) begin
                    state_next = KS_IDLE;
                end
                if (gap_reg >= GAP_WORD) begin
                    do_idle = 1'b1;
                end
            end
            KS_IDLE: begin
                do_idle = 1'b1;
            end
            KS_MAN_WAIT: begin
                if (past(start_dl_reg, now)) begin
                    state_next = KS_MAN_DOWN;
                end
            end
            KS_MAN_UP: begin
                if (past(read_dl_reg, now)) begin
                    state_next    = KS_IDLE;
                    staged_next   = EL_NONE;
                    start_dl_next = now + dot_t;
                    gap_next      = 3'd0;
                    if (code_reg[0]) begin
                        code_next = CODE_OVERFLOW;
                    end else begin
                        code_next = (code_reg >> 1) | CODE_EMPTY;
                    end
                end
            end
            default: ;
        endcase

        if (do_idle && past(start_dl_reg, now)) begin
            case (gap_reg)
                GAP_CHAR: begin
                    cvalid    = 1'b1;
                    ccode     = code_next;
                    code_next = CODE_EMPTY;
                    if (spacing_mode_reg >= SPACE_CHAR) begin
                        state_next = KS_GAP;
                    end
                end
                GAP_WORD: begin
                    cvalid = 1'b1;
                    ccode  = code_next;
                    if (spacing_mode_reg >= SPACE_WORD) begin
                        state_next = KS_GAP;
                    end
                end
                3'd5, 3'd6: begin
                    if (spacing_mode_reg >= SPACE_WORD) begin
                        state_next = KS_GAP;
                    end
                end
                default: ;
            endcase
            if (gap_next < GAP_MAX) begin
                gap_next = gap_next + 3'd1;
            end
            if (keyer_mode_reg == MODE_BUG) begin
                state_next = KS_IDLE;
            end
            start_dl_next = start_dl_next + dot_t;
        end

        // Bug and straight modes: the dah contact keys the line directly.
        if (keyer_mode_reg >= MODE_BUG) begin
            if (dah) begin
                if (state_next < KS_MAN_WAIT) begin
                    state_next    = KS_MAN_WAIT;
                    start_dl_next = now;
                end
                if (state_next < KS_MAN_UP) begin
                    read_dl_next = now;
                    key_on_next  = 1'b1;
                    rel_dl_next  = now;
                    started      = 1'b1;
                end
                last_el_next = EL_DAH;
                staged_next  = EL_NONE;
            end else if (state_next == KS_MAN_DOWN) begin
                if (staged_next == EL_DIT) begin
                    state_next = KS_IDLE;
                end else begin
                    state_next  = KS_MAN_UP;
                    key_on_next = 1'b1;
                    rel_dl_next = now;
                    started     = 1'b1;
                end
            end
        end else if (state_next > KS_IDLE) begin
            state_next = KS_MAN_UP;
        end

        if (staged_next == EL_NONE) begin
            if (state_next > KS_MARK) begin
                if (dit && dah) begin
                    if (squeeze_next && keyer_mode_reg == MODE_ULTIMATIC) begin
                        staged_next = last_el_next;
                    end else if (last_el_next == EL_DIT) begin
                        staged_next = EL_DAH;
                    end else begin
                        staged_next = EL_DIT;
                    end
                    squeeze_next = 1'b1;
                end else begin
                    if (dit) begin
                        staged_next = EL_DIT;
                    end
                    if (dah) begin
                        staged_next = EL_DAH;
                    end
                    squeeze_next = 1'b0;
                end
            end else if (!squeeze_next || keyer_mode_reg != MODE_ULTIMATIC) begin
                if (dit && (last_el_next == EL_DAH || gap_next != 3'd0) &&
                    memory_mask_reg[0]) begin
                    staged_next  = EL_DIT;
                    squeeze_next = 1'b1;
                end
                if (dah && (last_el_next == EL_DIT || gap_next != 3'd0) &&
                    memory_mask_reg[1]) begin
                    staged_next  = EL_DAH;
                    squeeze_next = 1'b1;
                end
            end
        end

        // Send the staged element.
        if (state_next == KS_IDLE && staged_next != EL_NONE) begin
            if (staged_next == EL_DAH) begin
                rel_dl_next = now + dah_key_reg;
                if (spacing_mode_reg >= SPACE_ELEMENT) begin
                    read_dl_next = now + dah_space_reg;
                end else begin
                    read_dl_next = now + dah_key_reg;
                end
            end else begin
                rel_dl_next = now + dit_key_reg;
                if (spacing_mode_reg >= SPACE_ELEMENT) begin
                    read_dl_next = now + dit_space_reg;
                end else begin
                    read_dl_next = now + dit_key_reg;
                end
            end
            start_dl_next = read_dl_next;
            key_on_next   = 1'b1;
            started       = 1'b1;
            gap_next      = 3'd0;
            if (code_next[0]) begin
                if (code_next != CODE_LAST || staged_next == EL_DAH) begin
                    code_next = CODE_OVERFLOW;
                end
            end else begin
                code_next = (code_next >> 1) |
                            ((staged_next == EL_DAH) ? CODE_EMPTY : 8'd0);
            end
            last_el_next = staged_next;
            staged_next  = EL_NONE;
            state_next   = KS_MARK;
        end

        // The release check sees a key that was turned on by this item too.
        if (key_on_next) begin
            if (past(rel_dl_next, now)) begin
                key_on_next = 1'b0;
            end
            released_next = !key_on_next;
        end

        result.key_active      = key_on_next;
        result.sidetone_on     = key_on_next && sidetone_reg;
        result.element_started = started;
        result.char_valid      = cvalid;
        result.char_code       = ccode;
        result.tx_released     = released_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= KS_IDLE;
            last_el_reg  <= EL_NONE;
            gap_reg      <= GAP_RESET;
            squeeze_reg  <= 1'b0;
            staged_reg   <= EL_NONE;
            code_reg     <= CODE_EMPTY;
            read_dl_reg  <= '0;
            start_dl_reg <= '0;
            rel_dl_reg   <= '0;
            key_on_reg   <= 1'b0;
            released_reg <= 1'b0;
        end else if (s_accept) begin
            state_reg    <= state_next;
            last_el_reg  <= last_el_next;
            gap_reg      <= gap_next;
            squeeze_reg  <= squeeze_next;
            staged_reg   <= staged_next;
            code_reg     <= code_next;
            read_dl_reg  <= read_dl_next;
            start_dl_reg <= start_dl_next;
            rel_dl_reg   <= rel_dl_next;
            key_on_reg   <= key_on_next;
            released_reg <= released_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry
    // ------------------------------------------------------------------
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;

    assign s_ready  = (busy_reg == 2'd0) && !skid_valid_reg;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= s_accept;
                end
            end else if (s_accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (s_accept) begin
                out_reg <= result;
            end
        end else if (s_accept) begin
            skid_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_key_active      = out_reg.key_active;
    assign m_sidetone_on     = out_reg.sidetone_on;
    assign m_element_started = out_reg.element_started;
    assign m_char_valid      = out_reg.char_valid;
    assign m_char_code       = out_reg.char_code;
    assign m_tx_released     = out_reg.tx_released;

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for iambic_morse_keyer. Items carry a tick stamp and
// the two paddle contacts. An in-bench model of the keyer predicts every
// result item, and each received item is compared field by field. Directed
// cases cover the eighth element, the four keying modes and the wrap of the
// tick counter. A long random run follows, in phases of different register
// settings, with held paddle patterns and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import imk_pkg::*;

    localparam int          PHASES          = 16;
    localparam int          ITEMS_PER_PHASE = 110;
    localparam int unsigned LIMIT_CYCLES    = 1000000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [31:0] s_time_now    = '0;
    logic        s_contact_a_n = 1'b1;
    logic        s_contact_b_n = 1'b1;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic        m_key_active;
    logic        m_sidetone_on;
    logic        m_element_started;
    logic        m_char_valid;
    logic [7:0]  m_char_code;
    logic        m_tx_released;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    iambic_morse_keyer u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_time_now        (s_time_now),
        .s_contact_a_n     (s_contact_a_n),
        .s_contact_b_n     (s_contact_b_n),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_key_active      (m_key_active),
        .m_sidetone_on     (m_sidetone_on),
        .m_element_started (m_element_started),
        .m_char_valid      (m_char_valid),
        .m_char_code       (m_char_code),
        .m_tx_released     (m_tx_released),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 aclk = ~aclk;

    // Register copy of the model.
    logic [1:0]  cfg_mode    = RST_KEYER_MODE;
    logic        cfg_swap    = 1'b0;
    logic [1:0]  cfg_spacing = RST_SPACING_MODE;
    logic [1:0]  cfg_mem     = RST_MEMORY_MASK;
    logic [23:0] cfg_dot     = RST_DOT_TICKS;
    logic [6:0]  cfg_weight  = RST_WEIGHT;
    logic [7:0]  cfg_lag     = 8'd0;
    logic        cfg_side    = 1'b1;

    // Keyer state of the model, at its reset values.
    logic [2:0]  k_state      = KS_IDLE;
    logic [1:0]  k_last       = EL_NONE;
    logic [2:0]  k_gaps       = GAP_RESET;
    logic        k_squeeze    = 1'b0;
    logic [1:0]  k_staged     = EL_NONE;
    logic [7:0]  k_code       = CODE_EMPTY;
    logic [31:0] k_read_dl    = '0;
    logic [31:0] k_start_dl   = '0;
    logic [31:0] k_release_dl = '0;
    logic        k_key        = 1'b0;
    logic        k_released   = 1'b0;

    result_t     keyer_outputs_due[$];
    int          error_count = 0;
    int unsigned cycles_run  = 0;
    logic [31:0] tick_now    = '0;
    logic        quiet_tx    = 1'b0;
    logic        quiet_rx    = 1'b0;

    // A deadline has passed when the wrapped difference to now is negative.
    function automatic logic deadline_passed(logic [31:0] deadline, logic [31:0] now);
        logic [31:0] diff;
        diff = deadline - now;
        return diff[31];
    endfunction

    function automatic result_t model_keyer_tick(logic [31:0] now, logic a_n, logic b_n);
        logic       a, b, dit, dah, do_idle, started, cvalid;
        logic [7:0] ccode;
        longint     dot, w, markadj, spaceadj;
        logic [31:0] t, kd;
        result_t    r;
        a = ~a_n;
        b = ~b_n;
        started = 1'b0;
        cvalid = 1'b0;
        ccode = '0;
        do_idle = 1'b0;
        dot = longint'(cfg_dot);

        if (cfg_mode == MODE_STRAIGHT) begin
            dit = 1'b0;
            dah = a;
        end else if (!cfg_swap) begin
            dit = a;
            dah = b;
        end else begin
            dit = b;
            dah = a;
        end

        case (k_state)
            KS_MARK: begin
                // Without spacing, a held paddle repeating the last element
                // cuts the read wait short.
                if (cfg_spacing == SPACE_NONE &&
                    ((dit && k_last == EL_DIT) || (dah && k_last == EL_DAH)))
                    k_read_dl = now;
                if (deadline_passed(k_read_dl, now)) k_state = KS_GAP;
            end
            KS_GAP: begin
                if (deadline_passed(k_start_dl, now)) k_state = KS_IDLE;
                if (k_gaps >= GAP_WORD) do_idle = 1'b1;
            end
            KS_IDLE: do_idle = 1'b1;
            KS_MAN_WAIT: begin
                if (deadline_passed(k_start_dl, now)) k_state = KS_MAN_DOWN;
            end
            KS_MAN_UP: begin
                if (deadline_passed(k_read_dl, now)) begin
                    k_state = KS_IDLE;
                    k_staged = EL_NONE;
                    k_start_dl = now + 32'(dot);
                    k_gaps = '0;
                    k_code = k_code[0] ? CODE_OVERFLOW : {1'b1, k_code[7:1]};
                end
            end
            default: ;
        endcase

        if (do_idle && deadline_passed(k_start_dl, now)) begin
            case (k_gaps)
                GAP_CHAR: begin
                    cvalid = 1'b1;
                    ccode = k_code;
                    k_code = CODE_EMPTY;
                    if (cfg_spacing >= SPACE_CHAR) k_state = KS_GAP;
                end
                GAP_WORD: begin
                    cvalid = 1'b1;
                    ccode = k_code;
                    if (cfg_spacing >= SPACE_WORD) k_state = KS_GAP;
                end
                GAP_WORD + 3'd1, GAP_WORD + 3'd2: begin
                    if (cfg_spacing >= SPACE_WORD) k_state = KS_GAP;
                end
                default: ;
            endcase
            if (k_gaps < GAP_MAX) k_gaps = k_gaps + 3'd1;
            if (cfg_mode == MODE_BUG) k_state = KS_IDLE;
            k_start_dl = k_start_dl + 32'(dot);
        end

        if (cfg_mode >= MODE_BUG) begin
            // The dah contact is a manual key in bug and straight modes.
            if (dah) begin
                if (k_state < KS_MAN_WAIT) begin
                    k_state = KS_MAN_WAIT;
                    k_start_dl = now;
                end
                if (k_state < KS_MAN_UP) begin
                    k_read_dl = now;
                    k_key = 1'b1;
                    k_release_dl = now;
                    started = 1'b1;
                end
                k_last = EL_DAH;
                k_staged = EL_NONE;
            end else if (k_state == KS_MAN_DOWN) begin
                if (k_staged == EL_DIT) k_state = KS_IDLE;
                else begin
                    k_state = KS_MAN_UP;
                    k_key = 1'b1;
                    k_release_dl = now;
                    started = 1'b1;
                end
            end
        end else if (k_state > KS_IDLE) begin
            k_state = KS_MAN_UP;
        end

        if (k_staged == EL_NONE) begin
            if (k_state > KS_MARK) begin
                if (dit && dah) begin
                    if (k_squeeze && cfg_mode == MODE_ULTIMATIC) k_staged = k_last;
                    else if (k_last == EL_DIT) k_staged = EL_DAH;
                    else k_staged = EL_DIT;
                    k_squeeze = 1'b1;
                end else begin
                    if (dit) k_staged = EL_DIT;
                    if (dah) k_staged = EL_DAH;
                    k_squeeze = 1'b0;
                end
            end else if (!k_squeeze || cfg_mode != MODE_ULTIMATIC) begin
                // Element memory while the current element is still sounding.
                if (dit && (k_last == EL_DAH || k_gaps > 0) && cfg_mem[0]) begin
                    k_staged = EL_DIT;
                    k_squeeze = 1'b1;
                end
                if (dah && (k_last == EL_DIT || k_gaps > 0) && cfg_mem[1]) begin
                    k_staged = EL_DAH;
                    k_squeeze = 1'b1;
                end
            end
        end

        if (k_state == KS_IDLE && k_staged != EL_NONE) begin
            w = longint'(cfg_weight);
            markadj = (dot * (2 * w - 100)) / 100;
            spaceadj = (dot * (200 - 2 * w)) / 100;
            t = now + 32'(longint'(k_staged) * dot + markadj);
            kd = t + 32'(longint'(cfg_lag) * TICKS_PER_MS);
            k_read_dl = kd;
            k_start_dl = kd;
            k_key = 1'b1;
            k_release_dl = kd;
            started = 1'b1;
            t = t + 32'(spaceadj);
            if (cfg_spacing >= SPACE_ELEMENT) begin
                k_read_dl = t;
                k_start_dl = t;
            end
            k_gaps = '0;
            if (k_code[0]) begin
                if (k_code != CODE_LAST || k_staged == EL_DAH) k_code = CODE_OVERFLOW;
            end else begin
                k_code = k_code >> 1;
                if (k_staged == EL_DAH) k_code[7] = 1'b1;
            end
            k_last = k_staged;
            k_staged = EL_NONE;
            k_state = KS_MARK;
        end

        if (k_key) begin
            if (deadline_passed(k_release_dl, now)) k_key = 1'b0;
            k_released = ~k_key;
        end

        r.key_active      = k_key;
        r.sidetone_on     = k_key & cfg_side;
        r.element_started = started;
        r.char_valid      = cvalid;
        r.char_code       = ccode;
        r.tx_released     = k_released;
        return r;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KEYER_MODE:   cfg_mode = value[1:0];
            REG_PADDLE_SWAP:  cfg_swap = value[0];
            REG_SPACING_MODE: cfg_spacing = value[1:0];
            REG_MEMORY_MASK:  cfg_mem = value[1:0];
            REG_DOT_TICKS:    cfg_dot = value[23:0];
            REG_WEIGHT:       cfg_weight = value[6:0];
            REG_LAG_MS:       cfg_lag = value[7:0];
            REG_SIDETONE:     cfg_side = value[0];
            default: ;
        endcase
    endtask

    task automatic program_keyer(input logic [1:0] mode, input logic swap,
                                 input logic [1:0] spacing, input logic [1:0] mem,
                                 input logic [23:0] dot, input logic [6:0] weight,
                                 input logic [7:0] lag, input logic side);
        reg_write(REG_KEYER_MODE, 32'(mode));
        reg_write(REG_PADDLE_SWAP, 32'(swap));
        reg_write(REG_SPACING_MODE, 32'(spacing));
        reg_write(REG_MEMORY_MASK, 32'(mem));
        reg_write(REG_DOT_TICKS, 32'(dot));
        reg_write(REG_WEIGHT, 32'(weight));
        reg_write(REG_LAG_MS, 32'(lag));
        reg_write(REG_SIDETONE, 32'(side));
    endtask

    task automatic send_tick(input logic [31:0] stamp, input logic a_n, input logic b_n);
        int unsigned gap;
        s_valid <= 1'b1;
        s_time_now <= stamp;
        s_contact_a_n <= a_n;
        s_contact_b_n <= b_n;
        do @(posedge aclk); while (!s_ready);
        keyer_outputs_due.push_back(model_keyer_tick(stamp, a_n, b_n));
        gap = quiet_tx ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Holds the sender off until every predicted item has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (keyer_outputs_due.size() != 0) @(posedge aclk);
    endtask

    // Zero dot length: eight dits leave the pattern at its last slot, the
    // dah after them overflows, and the character gap reports it.
    task automatic test_eighth_element();
        reg_write(REG_DOT_TICKS, 32'd0);
        tick_now = 32'd100;
        for (int i = 0; i < 21; i++) begin
            send_tick(tick_now, !(i < 15), !(i >= 15 && i < 17));
            tick_now = tick_now + 32'd1;
        end
    endtask

    // One squeeze in each keying mode, with weight above 100 and a lag.
    task automatic test_keying_modes();
        for (int m = 0; m < 4; m++) begin
            drain_results();
            program_keyer(2'(m), m[1], SPACE_ELEMENT, 2'b11, 24'd7, 7'd127, 8'd1, m[0]);
            tick_now = tick_now + 32'd3;
            send_tick(tick_now, 1'b0, 1'b0);
        end
    endtask

    task automatic test_time_wrap();
        send_tick(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_tick(32'h0000_0000, 1'b1, 1'b0);
        tick_now = 32'h0;
    endtask

    task automatic test_random_traffic();
        logic [1:0]  mode, spacing, mem, pattern;
        logic        swap, side, noisy;
        logic [23:0] dot;
        logic [6:0]  weight;
        logic [7:0]  lag;
        int unsigned hold_left, max_step;
        noisy = 1'b0;
        pattern = 2'b00;
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            if (p < 8) begin
                mode = 2'(p);
                swap = p[2];
            end else begin
                mode = 2'($urandom_range(0, 3));
                swap = 1'($urandom_range(0, 1));
            end
            spacing = 2'($urandom_range(0, 3));
            mem = 2'($urandom_range(0, 3));
            side = 1'($urandom_range(0, 1));
            case (p)
                0: begin
                    dot = 24'hFF_FFFF;
                    weight = 7'd0;
                    lag = 8'd255;
                end
                1: begin
                    dot = 24'd0;
                    weight = 7'd127;
                    lag = 8'd0;
                end
                2: begin
                    dot = 24'd1;
                    weight = 7'd100;
                    lag = 8'd0;
                end
                default: begin
                    dot = ($urandom_range(0, 9) == 0) ? 24'($urandom())
                                                      : 24'($urandom_range(1, 40));
                    weight = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                         : 7'($urandom_range(30, 70));
                    lag = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
                end
            endcase
            program_keyer(mode, swap, spacing, mem, dot, weight, lag, side);
            quiet_tx = (p == 2) || ($urandom_range(0, 3) == 0);
            quiet_rx = (p == 2) || ($urandom_range(0, 3) == 0);
            // Time steps scale with the element length so that elements,
            // gaps and characters complete within a phase.
            max_step = (32'(dot) + 32'(lag) * TICKS_PER_MS) / 2 + 2;
            hold_left = 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (hold_left == 0) begin
                    noisy = ($urandom_range(0, 9) == 0);
                    pattern = 2'($urandom_range(0, 3));
                    hold_left = $urandom_range(1, 15);
                end
                hold_left--;
                if (noisy) pattern = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 63) == 0)
                    tick_now = tick_now + $urandom_range(0, 32'h7FFF_FFFF);
                else
                    tick_now = tick_now + $urandom_range(0, max_step);
                send_tick(tick_now, ~pattern[0], ~pattern[1]);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_eighth_element();
        test_keying_modes();
        test_time_wrap();
        test_random_traffic();
        drain_results();
        repeat (4) @(posedge aclk);
        if (error_count == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

    // Result side: a fresh stall is drawn for every item.
    initial begin
        int unsigned stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = quiet_rx ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (keyer_outputs_due.size() == 0) begin
                $error("result item arrived with no prediction pending");
                error_count++;
            end else begin
                want = keyer_outputs_due.pop_front();
                check_field("key_active", want.key_active, m_key_active);
                check_field("sidetone_on", want.sidetone_on, m_sidetone_on);
                check_field("element_started", want.element_started, m_element_started);
                check_field("char_valid", want.char_valid, m_char_valid);
                check_field("char_code", want.char_code, m_char_code);
                check_field("tx_released", want.tx_released, m_tx_released);
            end
        end
    end

    always @(posedge aclk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run >= LIMIT_CYCLES) begin
            $display("tb: errors");
            $finish;
        end
    end

endmodule
